// ===== rtl/ardb_pkg.sv =====
// shared types, constants and codes of the aux ram dma register block
`default_nettype none
package ardb_pkg;

	// memory sizes behind the dma engine
	localparam int unsigned AUX_BYTES = 16777216;
	localparam int unsigned MAIN_BYTES = 25165824;
	localparam int unsigned AUX_AW = $clog2(AUX_BYTES);
	localparam int unsigned MAIN_AW = $clog2(MAIN_BYTES);
	localparam logic [31:0] AUX_MASK = 32'((64'd1 << AUX_AW) - 64'd1);
	localparam logic [31:0] MAIN_MASK = 32'((64'd1 << MAIN_AW) - 64'd1);

	// register window
	localparam logic [31:0] WIN_BASE = 32'hCC00_5000;

	// register offsets inside the window
	localparam logic [5:0] OFF_STATUS = 6'h0A;
	localparam logic [5:0] OFF_SIZE = 6'h12;
	localparam logic [5:0] OFF_MODE = 6'h16;
	localparam logic [5:0] OFF_REFRESH = 6'h1A;
	localparam logic [5:0] OFF_MAIN_HI = 6'h20;
	localparam logic [5:0] OFF_MAIN_LO = 6'h22;
	localparam logic [5:0] OFF_AUX_HI = 6'h24;
	localparam logic [5:0] OFF_AUX_LO = 6'h26;
	localparam logic [5:0] OFF_CNT_HI = 6'h28;
	localparam logic [5:0] OFF_CNT_LO = 6'h2A;

	// status register bits
	localparam logic [15:0] ST_RES = 16'h0001;
	localparam logic [15:0] ST_PIINT = 16'h0002;
	localparam logic [15:0] ST_HALT = 16'h0004;
	localparam logic [15:0] ST_AIDINT = 16'h0008;
	localparam logic [15:0] ST_AIDMSK = 16'h0010;
	localparam logic [15:0] ST_ARINT = 16'h0020;
	localparam logic [15:0] ST_ARMSK = 16'h0040;
	localparam logic [15:0] ST_DSPINT = 16'h0080;
	localparam logic [15:0] ST_DSPMSK = 16'h0100;
	localparam logic [15:0] ST_BUSY = 16'h0200;
	localparam logic [15:0] ST_INITCODE = 16'h0400;
	localparam logic [15:0] ST_INIT = 16'h0800;
	localparam logic [15:0] ST_W1C = ST_PIINT | ST_AIDINT | ST_ARINT | ST_DSPINT;
	localparam logic [15:0] ST_KEEP = ST_HALT | ST_AIDMSK | ST_ARMSK | ST_DSPMSK |
		ST_INITCODE | ST_INIT;
	localparam logic [15:0] ST_RESET = ST_HALT | ST_INIT;

	// busy countdown: 2025 + 2*len + floor((len >> 3) / 5)
	localparam logic [32:0] TICK_BASE = 33'd2025;
	localparam int unsigned DIV5_SHIFT = 30;
	localparam logic [27:0] DIV5_RECIP = 28'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK = 2'd2,
		OP_RAISE = 2'd3
	} op_t;

	typedef struct packed {
		logic to_main;
		logic [31:0] main_addr;
		logic [23:0] aux_addr;
		logic [30:0] length;
		logic range_error;
		logic [32:0] ticks;
	} dma_cmd_t;

	typedef struct packed {
		logic handled;
		logic [31:0] read_data;
		logic dma_start;
		logic dma_to_main;
		logic [31:0] dma_main_addr;
		logic [23:0] dma_aux_addr;
		logic [30:0] dma_length;
		logic dma_range_error;
		logic dsp_reset_pulse;
		logic dsp_boot_pulse;
		logic [2:0] irq_pending;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/aux_ram_dma_register_block_core.sv =====
// Aux RAM DMA and DSP control/status register block, top level.
// Items enter on the req channel: opcode selects a bus read, a bus write,
// one timebase tick or raising status bits from outside. Bus accesses hit a
// 64-byte register window; everything else is ignored with handled low.
// Every item gives exactly one result on the rsp channel: handled, read
// data, a dma command when a count write started a transfer, dsp reset and
// boot pulses, and the enabled pending interrupts after the item.
// An item is accepted when req_valid is high and req_stall low, and
// likewise for rsp. The item is registered on accept, decoded and executed
// against the registers while it waits in the input register, and its
// result lands in the output register when it advances, raising rsp_valid.
// One item per cycle is sustained while rsp_stall stays low; the register
// update and the dma length reciprocal multiply share the same cycle.
// When rsp_stall is high the output register holds its result; one more
// item waits in the input register, after which req_stall rises.
// Reset (arst_n low) empties both registers and sets status to halt and
// init with all dma registers cleared and no transfer busy.
`default_nettype none
module aux_ram_dma_register_block_core
	import ardb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [1:0] opcode,
	input wire logic [31:0] bus_address,
	input wire logic [3:0] access_size,
	input wire logic [31:0] write_value,
	input wire logic [15:0] raise_bits,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output logic handled,
	output logic [31:0] read_data,
	output logic dma_start,
	output logic dma_to_main,
	output logic [31:0] dma_main_addr,
	output logic [23:0] dma_aux_addr,
	output logic [30:0] dma_length,
	output logic dma_range_error,
	output logic dsp_reset_pulse,
	output logic dsp_boot_pulse,
	output logic [2:0] irq_pending
);

	logic valid_s1;
	logic [1:0] opcode_s1;
	logic [31:0] bus_address_s1;
	logic [3:0] access_size_s1;
	logic [31:0] write_value_s1;
	logic [15:0] raise_bits_s1;
	logic valid_s2;
	result_t rsp_s2;
	result_t res;
	logic advance;
	logic accept;

	assign advance = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept = req_valid && !req_stall;

	ardb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.commit(advance),
		.opcode(opcode_s1),
		.bus_address(bus_address_s1),
		.access_size(access_size_s1),
		.write_value(write_value_s1),
		.raise_bits(raise_bits_s1),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= 1'b1;
			else if (!rsp_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			bus_address_s1 <= bus_address;
			access_size_s1 <= access_size;
			write_value_s1 <= write_value;
			raise_bits_s1 <= raise_bits;
		end
		if (advance) rsp_s2 <= res;
	end

	assign rsp_valid = valid_s2;
	assign handled = rsp_s2.handled;
	assign read_data = rsp_s2.read_data;
	assign dma_start = rsp_s2.dma_start;
	assign dma_to_main = rsp_s2.dma_to_main;
	assign dma_main_addr = rsp_s2.dma_main_addr;
	assign dma_aux_addr = rsp_s2.dma_aux_addr;
	assign dma_length = rsp_s2.dma_length;
	assign dma_range_error = rsp_s2.dma_range_error;
	assign dsp_reset_pulse = rsp_s2.dsp_reset_pulse;
	assign dsp_boot_pulse = rsp_s2.dsp_boot_pulse;
	assign irq_pending = rsp_s2.irq_pending;

endmodule
`default_nettype wire

// ===== rtl/ardb_dma_calc.sv =====
// dma command decode: masked addresses, range check and busy countdown
`default_nettype none
module ardb_dma_calc
	import ardb_pkg::*;
(
	input wire logic [31:0] count,
	input wire logic [31:0] main_addr,
	input wire logic [31:0] aux_addr,
	output dma_cmd_t cmd
);

	logic [30:0] len;
	logic [31:0] aux_m;
	logic [31:0] mm_m;
	logic [32:0] aux_end;
	logic [32:0] main_end;
	logic [55:0] prod;
	logic [25:0] quot;

	assign len = count[30:0];
	assign aux_m = aux_addr & AUX_MASK;
	assign mm_m = main_addr & MAIN_MASK;
	assign aux_end = {1'b0, aux_m} + {2'b00, len};
	assign main_end = {1'b0, mm_m} + {2'b00, len};

	// len / 40 as (len / 8) / 5 via reciprocal, exact for 28-bit dividends
	assign prod = {28'd0, len[30:3]} * {28'd0, DIV5_RECIP};
	assign quot = prod[DIV5_SHIFT +: 26];

	always_comb begin
		cmd.to_main = count[31];
		cmd.main_addr = mm_m;
		cmd.aux_addr = aux_m[23:0];
		cmd.length = len;
		cmd.range_error = (aux_end > 33'(AUX_BYTES)) || (main_end > 33'(MAIN_BYTES));
		cmd.ticks = TICK_BASE + {1'b0, len, 1'b0} + {7'd0, quot};
	end

endmodule
`default_nettype wire

// ===== rtl/ardb_regs.sv =====
// register file, access decode and dma busy countdown
`default_nettype none
module ardb_regs
	import ardb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic commit,
	input wire logic [1:0] opcode,
	input wire logic [31:0] bus_address,
	input wire logic [3:0] access_size,
	input wire logic [31:0] write_value,
	input wire logic [15:0] raise_bits,
	output result_t res
);

	logic [15:0] status_q, size_q, mode_q, refresh_q, cnt_hi_q;
	logic [31:0] main_addr_q, aux_addr_q;
	logic busy_q;
	logic [32:0] ticks_q;

	logic [15:0] status_n, size_n, mode_n, refresh_n, cnt_hi_n;
	logic [31:0] main_addr_n, aux_addr_n;
	logic busy_n;
	logic [32:0] ticks_n;

	logic in_win;
	logic [5:0] off;
	logic full, half;
	logic [15:0] v16;
	logic [31:0] dma_count;
	logic [32:0] tick_dec;
	dma_cmd_t cmd;

	assign in_win = bus_address[31:6] == WIN_BASE[31:6];
	assign off = bus_address[5:0];
	assign full = access_size == 4'd4;
	assign half = access_size == 4'd2;
	assign v16 = write_value[15:0];
	assign dma_count = (off == OFF_CNT_HI) ? write_value : {cnt_hi_q, v16};
	assign tick_dec = (ticks_q != 33'd0) ? ticks_q - 33'd1 : ticks_q;

	ardb_dma_calc u_dma_calc (
		.count(dma_count),
		.main_addr(main_addr_q),
		.aux_addr(aux_addr_q),
		.cmd(cmd)
	);

	always_comb begin
		status_n = status_q;
		size_n = size_q;
		mode_n = mode_q;
		refresh_n = refresh_q;
		cnt_hi_n = cnt_hi_q;
		main_addr_n = main_addr_q;
		aux_addr_n = aux_addr_q;
		busy_n = busy_q;
		ticks_n = ticks_q;
		res = '0;

		unique case (op_t'(opcode))
			OP_READ: begin
				if (in_win) begin
					if (busy_q && ticks_q == 33'd0) begin
						busy_n = 1'b0;
						status_n = status_n | ST_ARINT;
					end
					res.handled = 1'b1;
					unique case (off)
						OFF_STATUS: begin
							res.handled = half;
							res.read_data = {16'd0, status_n | (busy_n ? ST_BUSY : 16'd0)};
						end
						OFF_SIZE: begin
							res.handled = half;
							res.read_data = {16'd0, size_q};
						end
						OFF_MODE: begin
							res.handled = half;
							res.read_data = {16'd0, mode_q | 16'd1};
						end
						OFF_REFRESH: begin
							res.handled = half;
							res.read_data = {16'd0, refresh_q};
						end
						OFF_MAIN_HI: res.read_data = full ? main_addr_q : {16'd0, main_addr_q[31:16]};
						OFF_MAIN_LO: begin
							res.handled = half;
							res.read_data = {16'd0, main_addr_q[15:0]};
						end
						OFF_AUX_HI: res.read_data = full ? aux_addr_q : {16'd0, aux_addr_q[31:16]};
						OFF_AUX_LO: begin
							res.handled = half;
							res.read_data = {16'd0, aux_addr_q[15:0]};
						end
						OFF_CNT_HI: res.read_data = full ? {cnt_hi_q, 16'd0} : {16'd0, cnt_hi_q};
						OFF_CNT_LO: res.read_data = 32'd0;
						default: res.handled = 1'b0;
					endcase
					// rejected reads return zero
					if (!res.handled) begin
						res.read_data = 32'd0;
					end
				end
			end
			OP_WRITE: begin
				if (in_win) begin
					res.handled = 1'b1;
					unique case (off)
						OFF_STATUS: begin
							res.handled = half;
							if (half) begin
								status_n = (status_q & ST_W1C & ~(v16 & ST_W1C)) | (v16 & ST_KEEP);
								res.dsp_reset_pulse = (v16 & ST_RES) != 16'd0;
								// init released: boot the dsp
								if ((status_q & ST_INIT) != 16'd0 && (v16 & ST_INIT) == 16'd0) begin
									status_n = status_n | ST_INITCODE;
									res.dsp_boot_pulse = 1'b1;
								end
							end
						end
						OFF_SIZE: begin
							res.handled = half;
							if (half) size_n = v16;
						end
						OFF_MODE: begin
							res.handled = half;
							if (half) mode_n = v16;
						end
						OFF_REFRESH: begin
							res.handled = half;
							if (half) refresh_n = v16;
						end
						OFF_MAIN_HI: main_addr_n = full ? write_value : {v16, main_addr_q[15:0]};
						OFF_MAIN_LO: begin
							res.handled = half;
							if (half) main_addr_n = {main_addr_q[31:16], v16};
						end
						OFF_AUX_HI: aux_addr_n = full ? write_value : {v16, aux_addr_q[15:0]};
						OFF_AUX_LO: begin
							res.handled = half;
							if (half) aux_addr_n = {aux_addr_q[31:16], v16};
						end
						OFF_CNT_HI: begin
							if (full) res.dma_start = 1'b1;
							else cnt_hi_n = v16;
						end
						OFF_CNT_LO: begin
							res.handled = half;
							res.dma_start = half;
						end
						default: res.handled = 1'b0;
					endcase
					if (res.dma_start) begin
						res.dma_to_main = cmd.to_main;
						res.dma_main_addr = cmd.main_addr;
						res.dma_aux_addr = cmd.aux_addr;
						res.dma_length = cmd.length;
						res.dma_range_error = cmd.range_error;
						busy_n = 1'b1;
						ticks_n = cmd.ticks;
					end
				end
			end
			OP_TICK: begin
				if (busy_q) begin
					ticks_n = tick_dec;
					if (tick_dec == 33'd0) begin
						busy_n = 1'b0;
						status_n = status_n | ST_ARINT;
					end
				end
			end
			OP_RAISE: status_n = status_q | raise_bits;
			default: res.handled = 1'b0;
		endcase

		res.irq_pending = {
			(status_n & ST_AIDINT) != 16'd0 && (status_n & ST_AIDMSK) != 16'd0,
			(status_n & ST_DSPINT) != 16'd0 && (status_n & ST_DSPMSK) != 16'd0,
			(status_n & ST_ARINT) != 16'd0 && (status_n & ST_ARMSK) != 16'd0
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_RESET;
			size_q <= 16'd0;
			mode_q <= 16'd0;
			refresh_q <= 16'd0;
			cnt_hi_q <= 16'd0;
			main_addr_q <= 32'd0;
			aux_addr_q <= 32'd0;
			busy_q <= 1'b0;
			ticks_q <= 33'd0;
		end else if (commit) begin
			status_q <= status_n;
			size_q <= size_n;
			mode_q <= mode_n;
			refresh_q <= refresh_n;
			cnt_hi_q <= cnt_hi_n;
			main_addr_q <= main_addr_n;
			aux_addr_q <= aux_addr_n;
			busy_q <= busy_n;
			ticks_q <= ticks_n;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ardb_checker.sv =====
// port-level checks of the register block, bound to the top level
`default_nettype none
module ardb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic handled,
	input wire logic [31:0] read_data,
	input wire logic dma_start,
	input wire logic dma_range_error,
	input wire logic dsp_reset_pulse,
	input wire logic dsp_boot_pulse
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(dma_start))
		else $error("stalled result changed");

	// rejected item gives no data and no side effects
	a_unhandled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !handled |-> read_data == 32'd0 && !dma_start && !dsp_reset_pulse
			&& !dsp_boot_pulse)
		else $error("unhandled item shows data or pulses");

	// a dma command only comes from a write, which returns no data
	a_dma_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dma_start |-> read_data == 32'd0 && !dsp_boot_pulse)
		else $error("dma start with read data or boot");

	// range flag only with a started transfer
	a_range_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && dma_range_error |-> dma_start)
		else $error("range error without dma start");

endmodule

bind aux_ram_dma_register_block_core ardb_checker u_ardb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.handled(handled),
	.read_data(read_data),
	.dma_start(dma_start),
	.dma_range_error(dma_range_error),
	.dsp_reset_pulse(dsp_reset_pulse),
	.dsp_boot_pulse(dsp_boot_pulse)
);
`default_nettype wire

// ===== tb/ardb_checker.sv =====
`timescale 1ns / 1ps
// checker for the aux ram dma register block: predicts every result and compares it
module ardb_tb_checker
	import ardb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic [1:0] opcode,
	input wire logic [31:0] bus_address,
	input wire logic [3:0] access_size,
	input wire logic [31:0] write_value,
	input wire logic [15:0] raise_bits,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic handled,
	input wire logic [31:0] read_data,
	input wire logic dma_start,
	input wire logic dma_to_main,
	input wire logic [31:0] dma_main_addr,
	input wire logic [23:0] dma_aux_addr,
	input wire logic [30:0] dma_length,
	input wire logic dma_range_error,
	input wire logic dsp_reset_pulse,
	input wire logic dsp_boot_pulse,
	input wire logic [2:0] irq_pending,
	output int mismatch_total,
	output int results_owed,
	output int items_checked,
	output int dma_commands,
	output int dma_out_of_range,
	output int countdowns_done
);

	// predicted register state
	logic [15:0] dsp_status;
	logic [15:0] size_word;
	logic [15:0] aram_mode;
	logic [15:0] aram_refresh;
	logic [31:0] mm_addr;
	logic [31:0] ar_addr;
	logic [15:0] count_hi;
	logic xfer_busy;
	logic [63:0] xfer_ticks;

	result_t due_results[$];
	int mismatch_count;
	int n_items;
	int n_starts;
	int n_oob;
	int n_done;

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what,
					want, got);
		end
	endfunction

	function automatic void expire_if_due();
		if (xfer_busy && xfer_ticks == 64'd0) begin
			xfer_busy = 1'b0;
			dsp_status |= ST_ARINT;
			n_done++;
		end
	endfunction

	function automatic void launch_transfer(input logic [31:0] cnt, inout result_t r);
		logic [30:0] len;
		logic [31:0] aux_m;
		logic [31:0] main_m;
		len = cnt[30:0];
		aux_m = ar_addr & AUX_MASK;
		main_m = mm_addr & MAIN_MASK;
		r.dma_start = 1'b1;
		r.dma_to_main = cnt[31];
		r.dma_main_addr = main_m;
		r.dma_aux_addr = aux_m[23:0];
		r.dma_length = len;
		r.dma_range_error = (64'(aux_m) + 64'(len) > 64'(AUX_BYTES)) ||
			(64'(main_m) + 64'(len) > 64'(MAIN_BYTES));
		xfer_busy = 1'b1;
		// restarts the countdown even when a transfer is already running
		xfer_ticks = 64'(TICK_BASE) + (64'(len) * 64'd81) / 64'd40;
	endfunction

	function automatic result_t apply_item(input op_t op, input logic [31:0] addr,
		input logic [3:0] sz, input logic [31:0] v, input logic [15:0] rb);
		result_t r;
		logic [31:0] rel;
		logic [31:0] data;
		logic [5:0] off;
		logic [15:0] was;
		logic full;
		logic hit;
		logic known;
		logic size_ok;
		r = '0;
		data = '0;
		rel = addr - WIN_BASE;
		off = rel[5:0];
		hit = (addr >= WIN_BASE) && (rel < 32'd64);
		full = (sz == 4'd4);
		known = 1'b1;
		case (op)
			OP_READ: if (hit) begin
				expire_if_due();
				size_ok = (sz == 4'd2) || off == OFF_MAIN_HI || off == OFF_AUX_HI ||
					off == OFF_CNT_HI || off == OFF_CNT_LO;
				case (off)
					OFF_STATUS: data = {16'd0, dsp_status | (xfer_busy ? ST_BUSY : 16'd0)};
					OFF_SIZE: data = {16'd0, size_word};
					OFF_MODE: data = {16'd0, aram_mode | 16'd1};
					OFF_REFRESH: data = {16'd0, aram_refresh};
					OFF_MAIN_HI: data = full ? mm_addr : {16'd0, mm_addr[31:16]};
					OFF_MAIN_LO: data = {16'd0, mm_addr[15:0]};
					OFF_AUX_HI: data = full ? ar_addr : {16'd0, ar_addr[31:16]};
					OFF_AUX_LO: data = {16'd0, ar_addr[15:0]};
					OFF_CNT_HI: data = full ? {count_hi, 16'd0} : {16'd0, count_hi};
					OFF_CNT_LO: data = '0;
					default: known = 1'b0;
				endcase
				if (known && size_ok) begin
					r.handled = 1'b1;
					r.read_data = data;
				end
			end
			OP_WRITE: if (hit) begin
				// the high halves take any size, everything else wants a half access
				size_ok = (sz == 4'd2) || off == OFF_MAIN_HI || off == OFF_AUX_HI ||
					off == OFF_CNT_HI;
				if (size_ok) begin
					case (off)
						OFF_STATUS: begin
							was = dsp_status;
							dsp_status = (dsp_status & ST_W1C & ~(v[15:0] & ST_W1C)) |
								(v[15:0] & ST_KEEP);
							if ((v[15:0] & ST_RES) != 16'd0)
								r.dsp_reset_pulse = 1'b1;
							// releasing init boots the dsp
							if ((was & ST_INIT) != 16'd0 && (v[15:0] & ST_INIT) == 16'd0) begin
								dsp_status |= ST_INITCODE;
								r.dsp_boot_pulse = 1'b1;
							end
						end
						OFF_SIZE: size_word = v[15:0];
						OFF_MODE: aram_mode = v[15:0];
						OFF_REFRESH: aram_refresh = v[15:0];
						OFF_MAIN_HI: mm_addr = full ? v : {v[15:0], mm_addr[15:0]};
						OFF_MAIN_LO: mm_addr = {mm_addr[31:16], v[15:0]};
						OFF_AUX_HI: ar_addr = full ? v : {v[15:0], ar_addr[15:0]};
						OFF_AUX_LO: ar_addr = {ar_addr[31:16], v[15:0]};
						OFF_CNT_HI: begin
							if (full)
								launch_transfer(v, r);
							else
								count_hi = v[15:0];
						end
						OFF_CNT_LO: launch_transfer({count_hi, v[15:0]}, r);
						default: known = 1'b0;
					endcase
				end
				r.handled = size_ok && known;
			end
			OP_TICK: if (xfer_busy) begin
				if (xfer_ticks != 64'd0)
					xfer_ticks--;
				expire_if_due();
			end
			default: dsp_status |= rb;
		endcase
		r.irq_pending = {(dsp_status & ST_AIDINT) != 0 && (dsp_status & ST_AIDMSK) != 0,
			(dsp_status & ST_DSPINT) != 0 && (dsp_status & ST_DSPMSK) != 0,
			(dsp_status & ST_ARINT) != 0 && (dsp_status & ST_ARMSK) != 0};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			dsp_status = ST_RESET;
			size_word = '0;
			aram_mode = '0;
			aram_refresh = '0;
			mm_addr = '0;
			ar_addr = '0;
			count_hi = '0;
			xfer_busy = 1'b0;
			xfer_ticks = '0;
			due_results.delete();
			mismatch_count = 0;
			n_items = 0;
			n_starts = 0;
			n_oob = 0;
			n_done = 0;
			mismatch_total <= 0;
			results_owed <= 0;
		end else begin
			// a result can never belong to the item accepted at this same edge
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result arrived with nothing outstanding", $realtime);
				end else begin
					want = due_results.pop_front();
					check_field("handled", want.handled, handled);
					check_field("read_data", want.read_data, read_data);
					check_field("dma_start", want.dma_start, dma_start);
					check_field("dma_to_main", want.dma_to_main, dma_to_main);
					check_field("dma_main_addr", want.dma_main_addr, dma_main_addr);
					check_field("dma_aux_addr", want.dma_aux_addr, dma_aux_addr);
					check_field("dma_length", want.dma_length, dma_length);
					check_field("dma_range_error", want.dma_range_error, dma_range_error);
					check_field("dsp_reset_pulse", want.dsp_reset_pulse, dsp_reset_pulse);
					check_field("dsp_boot_pulse", want.dsp_boot_pulse, dsp_boot_pulse);
					check_field("irq_pending", want.irq_pending, irq_pending);
				end
			end
			if (req_valid && !req_stall) begin
				want = apply_item(op_t'(opcode), bus_address, access_size, write_value,
					raise_bits);
				due_results.push_back(want);
				n_items++;
				if (want.dma_start)
					n_starts++;
				if (want.dma_range_error)
					n_oob++;
			end
			mismatch_total <= mismatch_count;
			results_owed <= due_results.size();
		end
		items_checked <= n_items;
		dma_commands <= n_starts;
		dma_out_of_range <= n_oob;
		countdowns_done <= n_done;
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench top: drives items into the register block and reports the verdict
module tb
	import ardb_pkg::*;
();

	localparam logic [5:0] REG_OFFSETS [10] = '{OFF_STATUS, OFF_SIZE, OFF_MODE, OFF_REFRESH,
		OFF_MAIN_HI, OFF_MAIN_LO, OFF_AUX_HI, OFF_AUX_LO, OFF_CNT_HI, OFF_CNT_LO};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic [1:0] opcode = '0;
	logic [31:0] bus_address = '0;
	logic [3:0] access_size = '0;
	logic [31:0] write_value = '0;
	logic [15:0] raise_bits = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	logic handled;
	logic [31:0] read_data;
	logic dma_start;
	logic dma_to_main;
	logic [31:0] dma_main_addr;
	logic [23:0] dma_aux_addr;
	logic [30:0] dma_length;
	logic dma_range_error;
	logic dsp_reset_pulse;
	logic dsp_boot_pulse;
	logic [2:0] irq_pending;

	int mismatch_total;
	int results_owed;
	int items_checked;
	int dma_commands;
	int dma_out_of_range;
	int countdowns_done;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;

	aux_ram_dma_register_block_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.bus_address(bus_address),
		.access_size(access_size),
		.write_value(write_value),
		.raise_bits(raise_bits),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.handled(handled),
		.read_data(read_data),
		.dma_start(dma_start),
		.dma_to_main(dma_to_main),
		.dma_main_addr(dma_main_addr),
		.dma_aux_addr(dma_aux_addr),
		.dma_length(dma_length),
		.dma_range_error(dma_range_error),
		.dsp_reset_pulse(dsp_reset_pulse),
		.dsp_boot_pulse(dsp_boot_pulse),
		.irq_pending(irq_pending)
	);

	ardb_tb_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.bus_address(bus_address),
		.access_size(access_size),
		.write_value(write_value),
		.raise_bits(raise_bits),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.handled(handled),
		.read_data(read_data),
		.dma_start(dma_start),
		.dma_to_main(dma_to_main),
		.dma_main_addr(dma_main_addr),
		.dma_aux_addr(dma_aux_addr),
		.dma_length(dma_length),
		.dma_range_error(dma_range_error),
		.dsp_reset_pulse(dsp_reset_pulse),
		.dsp_boot_pulse(dsp_boot_pulse),
		.irq_pending(irq_pending),
		.mismatch_total(mismatch_total),
		.results_owed(results_owed),
		.items_checked(items_checked),
		.dma_commands(dma_commands),
		.dma_out_of_range(dma_out_of_range),
		.countdowns_done(countdowns_done)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_asked;
			hold_left <= 60;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input op_t op, input logic [31:0] addr, input logic [3:0] sz,
		input logic [31:0] wv, input logic [15:0] rb);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		bus_address <= addr;
		access_size <= sz;
		write_value <= wv;
		raise_bits <= rb;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [5:0] off, input logic [3:0] sz, input logic [31:0] v);
		send_item(OP_WRITE, WIN_BASE + 32'(off), sz, v, 16'($urandom));
	endtask

	task automatic reg_read(input logic [5:0] off, input logic [3:0] sz);
		send_item(OP_READ, WIN_BASE + 32'(off), sz, $urandom, 16'($urandom));
	endtask

	task automatic tick();
		send_item(OP_TICK, $urandom, 4'($urandom), $urandom, 16'($urandom));
	endtask

	// stop offering and wait until every item has come back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	// a short transfer followed by enough ticks to run its countdown out
	task automatic run_transfer(input logic [30:0] len);
		int unsigned steps;
		logic dir;
		dir = 1'($urandom_range(1));
		reg_write(OFF_STATUS, 4'd2, 32'(ST_HALT | ST_ARMSK | ST_DSPMSK | ST_AIDMSK | ST_ARINT));
		reg_write(OFF_AUX_HI, 4'd4, $urandom_range(32'h00FF_0000));
		reg_write(OFF_MAIN_HI, 4'd4, $urandom_range(32'h0100_0000));
		if ($urandom_range(1)) begin
			reg_write(OFF_CNT_HI, 4'd4, {dir, len});
		end else begin
			reg_write(OFF_CNT_HI, 4'd2, {16'd0, dir, len[30:16]});
			reg_write(OFF_CNT_LO, 4'd2, {16'd0, len[15:0]});
		end
		steps = 2025 + (int'(len) * 81) / 40 + $urandom_range(3);
		repeat (steps) begin
			if ($urandom_range(199) == 0)
				reg_read(OFF_STATUS, 4'd2);
			tick();
		end
		reg_read(OFF_STATUS, 4'd2);
	endtask

	task automatic random_item();
		int unsigned pick;
		logic [31:0] addr;
		logic [31:0] wv;
		logic [3:0] sz;
		op_t op;
		pick = $urandom_range(99);
		op = pick < 35 ? OP_READ : pick < 75 ? OP_WRITE : pick < 92 ? OP_TICK : OP_RAISE;
		// mostly real registers, some odd offsets and some bus noise
		pick = $urandom_range(99);
		if (pick < 80)
			addr = WIN_BASE + 32'(REG_OFFSETS[$urandom_range(9)]);
		else if (pick < 90)
			addr = WIN_BASE + $urandom_range(63);
		else
			addr = $urandom;
		pick = $urandom_range(99);
		sz = pick < 50 ? 4'd2 : pick < 80 ? 4'd4 : 4'($urandom_range(15));
		pick = $urandom_range(2);
		wv = pick == 0 ? $urandom : pick == 1 ? $urandom_range(255) : 32'd1 << $urandom_range(31);
		send_item(op, addr, sz, wv, 16'($urandom) & 16'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read(OFF_STATUS, 4'd2);
		tick();
		reg_read(OFF_MODE, 4'd2);
		reg_write(OFF_STATUS, 4'd2, 32'h0000_0000);
		reg_write(OFF_STATUS, 4'd2, 32'hFFFF_FFFF);
		send_item(OP_RAISE, 32'h0, 4'd0, 32'h0, 16'hFFFF);
		reg_read(OFF_STATUS, 4'd4);
		reg_write(OFF_STATUS, 4'd2, 32'h0000_00AA);
		reg_write(OFF_SIZE, 4'd2, 32'h0000_FFFF);
		reg_write(OFF_MODE, 4'd4, 32'h0000_1234);
		reg_write(OFF_REFRESH, 4'd2, 32'h0000_8001);
		reg_write(OFF_MAIN_HI, 4'd4, 32'hFFFF_FFFF);
		reg_write(OFF_MAIN_LO, 4'd2, 32'h0000_0000);
		reg_write(OFF_MAIN_HI, 4'd1, 32'h0000_0100);
		reg_read(OFF_MAIN_HI, 4'd4);
		reg_write(OFF_AUX_HI, 4'd4, 32'h00FF_FFF0);
		reg_write(OFF_AUX_LO, 4'd2, 32'h0000_1234);
		reg_read(OFF_AUX_HI, 4'd2);
		// half count writes start a transfer, a full one restarts it out of range
		reg_write(OFF_CNT_HI, 4'd2, 32'h0000_8000);
		reg_write(OFF_CNT_LO, 4'd2, 32'h0000_0020);
		reg_write(OFF_CNT_HI, 4'd4, 32'h7FFF_FFFF);
		reg_read(OFF_CNT_HI, 4'd4);
		reg_read(OFF_CNT_LO, 4'd8);
		send_item(OP_READ, 32'hCC00_4FFE, 4'd2, 32'h0, 16'h0);
		send_item(OP_WRITE, WIN_BASE + 32'd64, 4'd2, 32'hFFFF_FFFF, 16'h0);
		reg_read(6'h0B, 4'd2);
		drain();
		run_transfer(31'd0);
		drain();

		for (int blk = 0; blk < 8; blk++) begin
			case (blk % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_gap_pct = 56;
					stall_pct <= 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct <= 56;
				end
				default: begin
					send_gap_pct = 6;
					stall_pct <= 6;
				end
			endcase
			// long output hold while items keep coming, so the input backs up
			if (blk == 0)
				hold_asked <= hold_asked + 1;
			repeat (50)
				random_item();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("summary: %0d items, %0d dma commands (%0d out of range), %0d countdowns ran out",
			items_checked, dma_commands, dma_out_of_range, countdowns_done);
		$display("summary: one full countdown, four idle mixes, one long output hold, drains");
		if (mismatch_total == 0 && results_owed == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: errors");
		$finish;
	end

endmodule

// ===== aux_ram_dma_register_block_core.f =====
rtl/ardb_pkg.sv
rtl/ardb_dma_calc.sv
rtl/ardb_regs.sv
rtl/aux_ram_dma_register_block_core.sv
rtl/ardb_checker.sv
tb/ardb_checker.sv
tb/tb.sv
